/* rtl/spmq_pkg.sv */
// ----------------------------------------------------------------------------
// spmq_pkg
// Shared types and codes for the strict priority multi-queue unit.
// ----------------------------------------------------------------------------
package spmq_pkg;

  localparam int LVL_W  = 3;
  localparam int DATA_W = 32;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_ENQ     = 3'd0,
    ST_DEQ     = 3'd1,
    ST_BADPRIO = 3'd2,
    ST_OVER    = 3'd3,
    ST_UNDER   = 3'd4
  } status_t;

  typedef struct packed {
    cmd_t                      command;
    logic signed [DATA_W-1:0]  value;
    logic        [LVL_W-1:0]   priority_req;
  } req_t;

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  data_out;
    logic        [LVL_W-1:0]   level_out;
  } rsp_t;

  // Outcome of one queue operation, from the pointer logic to the pipeline
  typedef struct packed {
    logic                      we;
    logic                      re;
    status_t                   status;
    logic        [LVL_W-1:0]   level;
  } acc_t;

endpackage

/* rtl/spmq_ram.sv */
// ----------------------------------------------------------------------------
// spmq_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module spmq_ram #(
  parameter int WIDTH = 32,
  parameter int WORDS = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(WORDS)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(WORDS)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/spmq_ctrl.sv */
// ----------------------------------------------------------------------------
// spmq_ctrl
// Per-level head, tail and occupancy registers, priority selection and
// entry address generation for one operation per cycle in which fire is set.
// ----------------------------------------------------------------------------
module spmq_ctrl
  import spmq_pkg::*;
#(
  parameter int LEVELS = 4,
  parameter int DEPTH  = 8,
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1,
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int OW = $clog2(DEPTH + 1),
  localparam int AW = $clog2(LEVELS * DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  req_t          item,
  output acc_t          acc,
  output logic [AW-1:0] addr
);

  localparam logic [LVL_W:0] LEVELS_V = (LVL_W + 1)'(LEVELS);
  localparam logic [OW-1:0]  FULL_V   = OW'(DEPTH);
  localparam logic [IW-1:0]  LAST_V   = IW'(DEPTH - 1);

  logic [IW-1:0] head [LEVELS];
  logic [IW-1:0] tail [LEVELS];
  logic [OW-1:0] occ  [LEVELS];

  logic [LW-1:0] enq_lvl;
  logic          lvl_ok;
  logic          full;
  logic [LW-1:0] sel;
  logic          found;
  logic [LW-1:0] lvl;
  logic [IW-1:0] slot;
  logic [IW-1:0] slot_inc;

  assign enq_lvl = item.priority_req[LW-1:0];
  assign lvl_ok  = {1'b0, item.priority_req} < LEVELS_V;
  assign full    = lvl_ok && (occ[enq_lvl] == FULL_V);

  // Lowest-numbered non-empty level wins
  always_comb begin
    sel   = '0;
    found = 1'b0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (occ[i] != '0) begin
        sel   = LW'(i);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    acc = '0;
    if (item.command == CMD_ENQ) begin
      lvl = enq_lvl;
      if (!lvl_ok) begin
        acc.status = ST_BADPRIO;
      end else if (full) begin
        acc.status = ST_OVER;
      end else begin
        acc.status = ST_ENQ;
        acc.we     = 1'b1;
        acc.level  = LVL_W'(enq_lvl);
      end
    end else begin
      lvl = sel;
      if (found) begin
        acc.status = ST_DEQ;
        acc.re     = 1'b1;
        acc.level  = LVL_W'(sel);
      end else begin
        acc.status = ST_UNDER;
      end
    end
    slot     = (item.command == CMD_ENQ) ? tail[lvl] : head[lvl];
    slot_inc = (slot == LAST_V) ? '0 : slot + 1'b1;
  end

  assign addr = AW'(lvl) * AW'(DEPTH) + AW'(slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        occ[i]  <= '0;
      end
    end else if (fire) begin
      if (acc.we) begin
        tail[lvl] <= slot_inc;
        occ[lvl]  <= occ[lvl] + 1'b1;
      end
      if (acc.re) begin
        head[lvl] <= slot_inc;
        occ[lvl]  <= occ[lvl] - 1'b1;
      end
    end
  end

endmodule

/* rtl/strict_priority_multi_queue_unit.sv */
// An accepted request is registered in s1, then s2, then the response register.
// Throughput: one transaction per cycle, limited by the single RAM read port
// and the pointer update loop; response back-pressure stalls the pipe.
// Reset clears all head, tail and occupancy registers, so every level is empty.
// Entry RAM contents are not cleared; an entry is only read after being written.
// ----------------------------------------------------------------------------
// strict_priority_multi_queue_unit
// LEVELS circular FIFOs of DEPTH words with strict priority dequeue.
// ----------------------------------------------------------------------------
module strict_priority_multi_queue_unit
  import spmq_pkg::*;
#(
  parameter int LEVELS = 4,
  parameter int DEPTH  = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int AW = $clog2(LEVELS * DEPTH);

  logic              adv;
  logic              fire;
  logic              s1_valid;
  req_t              s1_item;
  logic              s2_valid;
  status_t           s2_status;
  logic [LVL_W-1:0]  s2_level;
  logic              s2_deq;
  acc_t              acc;
  logic [AW-1:0]     addr;
  logic [DATA_W-1:0] ram_rdata;

  assign adv       = !rsp_valid || rsp_ready;
  assign req_ready = !s1_valid || adv;
  assign fire      = s1_valid && adv;

  spmq_ctrl #(
    .LEVELS (LEVELS),
    .DEPTH  (DEPTH)
  ) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (s1_item),
    .acc  (acc),
    .addr (addr)
  );

  spmq_ram #(
    .WIDTH (DATA_W),
    .WORDS (LEVELS * DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (fire && acc.we),
    .waddr (addr),
    .wdata (s1_item.value),
    .re    (fire && acc.re),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv) begin
        s2_valid  <= s1_valid;
        rsp_valid <= s2_valid;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1_item <= req;
    end
    if (adv) begin
      s2_status     <= acc.status;
      s2_level      <= acc.level;
      s2_deq        <= acc.re;
      rsp.status    <= s2_status;
      rsp.level_out <= s2_level;
      // RAM output still holds the word read when s2 was loaded
      rsp.data_out  <= s2_deq ? ram_rdata : '0;
    end
  end

  a_no_rw_together: assert property (@(posedge clk) disable iff (rst)
    !(fire && acc.we && acc.re))
    else $error("queue write and read issued in the same cycle");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |=> s1_valid && $stable(s1_item))
    else $error("stalled input stage lost its transaction");

  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_DEQ |-> rsp.data_out == '0)
    else $error("non-dequeue response carries data");

  a_err_level: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_BADPRIO || rsp.status == ST_OVER ||
                  rsp.status == ST_UNDER) |-> rsp.level_out == '0)
    else $error("error response carries a level");

endmodule
